>>> rtl/bpcr_pkg.sv
// ============================================================================
// bpcr_pkg
// Shared widths, register indexes and reset values for the bulge/pinch
// coordinate remap.
// ============================================================================
package bpcr_pkg;

   localparam int PIXEL_W      = 12;
   localparam int OUT_W        = 22;
   localparam int CENTER_W     = 16;
   localparam int INV_RADIUS_W = 20;
   localparam int STRENGTH_W   = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 20;

   localparam int CENTER_FRAC  = 4;
   localparam int D_FRAC       = 16;
   localparam int FACTOR_FRAC  = 30;
   localparam int FACTOR_W     = 34;
   localparam int PROD_FRAC    = CENTER_FRAC + FACTOR_FRAC;
   localparam int SPLIT_W      = 17;

   localparam logic [CENTER_W-1:0]     CENTER_X_RESET   = 16'd32768;
   localparam logic [CENTER_W-1:0]     CENTER_Y_RESET   = 16'd32768;
   localparam logic [INV_RADIUS_W-1:0] INV_RADIUS_RESET = 20'd10486;
   localparam logic [STRENGTH_W-1:0]   STRENGTH_RESET   = 16'd8192;

   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_X   = 2'd0,
      CSR_CENTER_Y   = 2'd1,
      CSR_INV_RADIUS = 2'd2,
      CSR_STRENGTH   = 2'd3
   } csr_index_type;

endpackage

>>> rtl/bulge_pinch_coordinate_remap.sv
// ============================================================================
// bulge_pinch_coordinate_remap
// Maps an output pixel coordinate to the source sampling coordinate of a
// radial bulge or pinch, fixed point, saturated to the output range.
// ============================================================================
// Throughput: one request per cycle while rsp_ready does not stall the pipeline.
// The pipeline depth is set by the square root pipeline, one root bit per stage.
// Reset clears all stage valid bits and loads the CSR reset values.
module bulge_pinch_coordinate_remap
   import bpcr_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [PIXEL_W-1:0]            req_pixel_x,
   input  logic [PIXEL_W-1:0]            req_pixel_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [OUT_W-1:0]       rsp_source_x,
   output logic signed [OUT_W-1:0]       rsp_source_y,
   output logic                          rsp_inside_region,
   input  logic                          csr_write_en,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   localparam int PXW  = COORD_BITS;
   localparam int UW   = (COORD_BITS + CENTER_FRAC > CENTER_W) ?
                         COORD_BITS + CENTER_FRAC : CENTER_W;
   localparam int DW   = UW + 1;
   localparam int SW   = 2 * UW + 1;
   localparam int RW   = UW + 1;
   localparam int DPW  = RW + INV_RADIUS_W;
   localparam int DSH  = CENTER_FRAC + INV_RADIUS_W - D_FRAC;
   localparam int TDW  = D_FRAC + 1;
   localparam int PLW  = DW + SPLIT_W + 1;
   localparam int PHW  = DW + FACTOR_W - SPLIT_W;
   localparam int PW   = DW + FACTOR_W;
   localparam int SH   = PROD_FRAC - FRAC_BITS;
   localparam int SCW  = PW - SH;
   localparam int TW   = SCW + 2;
   localparam int PIXW = PXW + FRAC_BITS;

   localparam int S_OFF  = 0;
   localparam int S_ABS  = 1;
   localparam int S_SQ   = 2;
   localparam int S_SUM  = 3;
   localparam int S_ROOT = S_SUM + RW;
   localparam int S_DIST = S_ROOT + 1;
   localparam int S_T    = S_ROOT + 2;
   localparam int S_T2   = S_ROOT + 3;
   localparam int S_ST   = S_ROOT + 4;
   localparam int S_FAC  = S_ROOT + 5;
   localparam int S_PP   = S_ROOT + 6;
   localparam int S_PROD = S_ROOT + 7;
   localparam int S_SCL  = S_ROOT + 8;
   localparam int S_OUT  = S_ROOT + 9;
   localparam int NS     = S_OUT + 1;

   localparam logic [DW-1:0]              HALF_PIXEL = DW'(1) << (CENTER_FRAC - 1);
   localparam logic [TDW-1:0]             T_ONE      = TDW'(1) << D_FRAC;
   localparam logic signed [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1) << FACTOR_FRAC;
   localparam logic signed [PW-1:0]       ROUND_HALF = PW'(1) << (SH - 1);
   localparam logic signed [TW-1:0]       OUT_HALF   = TW'(1) << (FRAC_BITS - 1);
   localparam logic signed [TW-1:0]       SAT_MAX    = TW'(OUT_MAX);
   localparam logic signed [TW-1:0]       SAT_MIN    = TW'(OUT_MIN);

   // configuration registers
   logic [CENTER_W-1:0]            center_x_ff;
   logic [CENTER_W-1:0]            center_y_ff;
   logic [INV_RADIUS_W-1:0]        inv_radius_ff;
   logic signed [STRENGTH_W-1:0]   strength_ff;

   // pipeline control
   logic [NS-1:0]                  valid_ff;
   logic [NS-1:0]                  stage_ready;

   // carried fields
   logic [PXW-1:0]                 pix_x_ff  [0:S_OUT-1];
   logic [PXW-1:0]                 pix_y_ff  [0:S_OUT-1];
   logic signed [DW-1:0]           off_x_ff  [0:S_PP-1];
   logic signed [DW-1:0]           off_y_ff  [0:S_PP-1];
   logic                           region_ff [S_DIST:S_OUT-1];

   // stage data
   logic [PXW-1:0]                 pix_x_in;
   logic [PXW-1:0]                 pix_y_in;
   logic [DW-1:0]                  pos_x_in;
   logic [DW-1:0]                  pos_y_in;
   logic [DW-1:0]                  neg_x_in;
   logic [DW-1:0]                  neg_y_in;
   logic [UW-1:0]                  mag_x_ff;
   logic [UW-1:0]                  mag_y_ff;
   logic [2*UW-1:0]                sq_x_ff;
   logic [2*UW-1:0]                sq_y_ff;
   logic [SW-1:0]                  rem_ff    [0:RW-1];
   logic [SW:0]                    root_ff   [1:RW];
   logic [RW-1:0]                  root_dist;
   logic [DPW-1:0]                 dprod_in;
   logic [D_FRAC-1:0]              dlow_ff;
   logic [TDW-1:0]                 t_ff;
   logic [2*TDW-1:0]               tsq_in;
   logic [TDW-1:0]                 t2_ff;
   logic signed [FACTOR_W-1:0]     st_ff;
   logic signed [FACTOR_W-1:0]     factor_ff;
   logic signed [PLW-1:0]          lo_x_ff;
   logic signed [PLW-1:0]          lo_y_ff;
   logic signed [PHW-1:0]          hi_x_ff;
   logic signed [PHW-1:0]          hi_y_ff;
   logic signed [PW-1:0]           prod_x_ff;
   logic signed [PW-1:0]           prod_y_ff;
   logic signed [PW-1:0]           rnd_x_in;
   logic signed [PW-1:0]           rnd_y_in;
   logic signed [SCW-1:0]          scl_x_ff;
   logic signed [SCW-1:0]          scl_y_ff;
   logic signed [TW-1:0]           sel_x_in;
   logic signed [TW-1:0]           sel_y_in;
   logic signed [OUT_W-1:0]        src_x_in;
   logic signed [OUT_W-1:0]        src_y_in;
   logic signed [OUT_W-1:0]        src_x_ff;
   logic signed [OUT_W-1:0]        src_y_ff;
   logic                           out_region_ff;

   // ------------------------------------------------------------------------
   // configuration
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff   <= CENTER_X_RESET;
         center_y_ff   <= CENTER_Y_RESET;
         inv_radius_ff <= INV_RADIUS_RESET;
         strength_ff   <= STRENGTH_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_CENTER_X:   center_x_ff   <= csr_wdata[CENTER_W-1:0];
            CSR_CENTER_Y:   center_y_ff   <= csr_wdata[CENTER_W-1:0];
            CSR_INV_RADIUS: inv_radius_ff <= csr_wdata[INV_RADIUS_W-1:0];
            CSR_STRENGTH:   strength_ff   <= $signed(csr_wdata[STRENGTH_W-1:0]);
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // pipeline control: a stage advances when empty or when the next advances
   // ------------------------------------------------------------------------
   always_comb begin
      stage_ready[NS-1] = !valid_ff[NS-1] || rsp_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_ready[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_ready = stage_ready[0];
   assign rsp_valid = valid_ff[NS-1];

   // ------------------------------------------------------------------------
   // offset from pixel center to bulge center
   // ------------------------------------------------------------------------
   assign pix_x_in = PXW'(req_pixel_x);
   assign pix_y_in = PXW'(req_pixel_y);
   assign pos_x_in = (DW'(pix_x_in) << CENTER_FRAC) | HALF_PIXEL;
   assign pos_y_in = (DW'(pix_y_in) << CENTER_FRAC) | HALF_PIXEL;

   always_ff @(posedge clock) begin
      if (stage_ready[S_OFF]) begin
         pix_x_ff[S_OFF] <= pix_x_in;
         pix_y_ff[S_OFF] <= pix_y_in;
         off_x_ff[S_OFF] <= $signed(pos_x_in - DW'(center_x_ff));
         off_y_ff[S_OFF] <= $signed(pos_y_in - DW'(center_y_ff));
      end
   end

   for (genvar k = 1; k < S_OUT; k++) begin : g_carry_pix
      always_ff @(posedge clock) begin
         if (stage_ready[k]) begin
            pix_x_ff[k] <= pix_x_ff[k-1];
            pix_y_ff[k] <= pix_y_ff[k-1];
         end
      end
   end

   for (genvar k = 1; k < S_PP; k++) begin : g_carry_off
      always_ff @(posedge clock) begin
         if (stage_ready[k]) begin
            off_x_ff[k] <= off_x_ff[k-1];
            off_y_ff[k] <= off_y_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------------
   // magnitude, squares and sum of squares
   // ------------------------------------------------------------------------
   assign neg_x_in = -off_x_ff[S_ABS-1];
   assign neg_y_in = -off_y_ff[S_ABS-1];

   always_ff @(posedge clock) begin
      if (stage_ready[S_ABS]) begin
         mag_x_ff <= off_x_ff[S_ABS-1][DW-1] ? UW'(neg_x_in) : UW'(off_x_ff[S_ABS-1]);
         mag_y_ff <= off_y_ff[S_ABS-1][DW-1] ? UW'(neg_y_in) : UW'(off_y_ff[S_ABS-1]);
      end
      if (stage_ready[S_SQ]) begin
         sq_x_ff <= (2*UW)'(mag_x_ff) * (2*UW)'(mag_x_ff);
         sq_y_ff <= (2*UW)'(mag_y_ff) * (2*UW)'(mag_y_ff);
      end
      if (stage_ready[S_SUM]) begin
         rem_ff[0] <= SW'(sq_x_ff) + SW'(sq_y_ff);
      end
   end

   // ------------------------------------------------------------------------
   // square root, one root bit per stage
   // ------------------------------------------------------------------------
   for (genvar j = 1; j <= RW; j++) begin : g_root
      localparam logic [SW:0] ROOT_BIT = (SW+1)'(1) << (2 * (RW - j));
      logic [SW:0] root_prev;
      logic [SW:0] trial;
      logic        take;

      if (j == 1) begin : g_first
         assign root_prev = '0;
      end else begin : g_next
         assign root_prev = root_ff[j-1];
      end

      assign trial = root_prev + ROOT_BIT;
      assign take  = {1'b0, rem_ff[j-1]} >= trial;

      always_ff @(posedge clock) begin
         if (stage_ready[S_SUM+j]) begin
            root_ff[j] <= take ? (root_prev >> 1) + ROOT_BIT : root_prev >> 1;
         end
      end

      if (j < RW) begin : g_rem
         always_ff @(posedge clock) begin
            if (stage_ready[S_SUM+j]) begin
               rem_ff[j] <= take ? SW'({1'b0, rem_ff[j-1]} - trial) : rem_ff[j-1];
            end
         end
      end
   end

   assign root_dist = root_ff[RW][RW-1:0];

   // ------------------------------------------------------------------------
   // normalized distance, falloff and scale factor
   // ------------------------------------------------------------------------
   assign dprod_in = DPW'(root_dist) * DPW'(inv_radius_ff);
   assign tsq_in   = (2*TDW)'(t_ff) * (2*TDW)'(t_ff);

   always_ff @(posedge clock) begin
      if (stage_ready[S_DIST]) begin
         region_ff[S_DIST] <= dprod_in[DPW-1:DSH+D_FRAC] == '0;
         dlow_ff           <= dprod_in[DSH+D_FRAC-1:DSH];
      end
      if (stage_ready[S_T]) begin
         t_ff <= T_ONE - {1'b0, dlow_ff};
      end
      if (stage_ready[S_T2]) begin
         t2_ff <= tsq_in[D_FRAC+TDW-1:D_FRAC];
      end
      if (stage_ready[S_ST]) begin
         st_ff <= strength_ff * $signed({1'b0, t2_ff});
      end
      if (stage_ready[S_FAC]) begin
         factor_ff <= FACTOR_ONE - st_ff;
      end
   end

   for (genvar k = S_DIST + 1; k < S_OUT; k++) begin : g_carry_region
      always_ff @(posedge clock) begin
         if (stage_ready[k]) begin
            region_ff[k] <= region_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------------
   // scale offsets: split multiply, recombine, round half up
   // ------------------------------------------------------------------------
   assign rnd_x_in = prod_x_ff + ROUND_HALF;
   assign rnd_y_in = prod_y_ff + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (stage_ready[S_PP]) begin
         lo_x_ff <= off_x_ff[S_PP-1] * $signed({1'b0, factor_ff[SPLIT_W-1:0]});
         lo_y_ff <= off_y_ff[S_PP-1] * $signed({1'b0, factor_ff[SPLIT_W-1:0]});
         hi_x_ff <= off_x_ff[S_PP-1] * $signed(factor_ff[FACTOR_W-1:SPLIT_W]);
         hi_y_ff <= off_y_ff[S_PP-1] * $signed(factor_ff[FACTOR_W-1:SPLIT_W]);
      end
      if (stage_ready[S_PROD]) begin
         prod_x_ff <= (PW'(hi_x_ff) <<< SPLIT_W) + PW'(lo_x_ff);
         prod_y_ff <= (PW'(hi_y_ff) <<< SPLIT_W) + PW'(lo_y_ff);
      end
      if (stage_ready[S_SCL]) begin
         scl_x_ff <= $signed(rnd_x_in[PW-1:SH]);
         scl_y_ff <= $signed(rnd_y_in[PW-1:SH]);
      end
   end

   // ------------------------------------------------------------------------
   // recenter, pass through outside the circle, saturate
   // ------------------------------------------------------------------------
   always_comb begin
      if (region_ff[S_OUT-1]) begin
         sel_x_in = $signed(TW'(center_x_ff) << (FRAC_BITS - CENTER_FRAC))
                    + TW'(scl_x_ff) - OUT_HALF;
         sel_y_in = $signed(TW'(center_y_ff) << (FRAC_BITS - CENTER_FRAC))
                    + TW'(scl_y_ff) - OUT_HALF;
      end else begin
         sel_x_in = $signed(TW'(PIXW'(pix_x_ff[S_OUT-1]) << FRAC_BITS));
         sel_y_in = $signed(TW'(PIXW'(pix_y_ff[S_OUT-1]) << FRAC_BITS));
      end

      if (sel_x_in > SAT_MAX) begin
         src_x_in = OUT_MAX;
      end else if (sel_x_in < SAT_MIN) begin
         src_x_in = OUT_MIN;
      end else begin
         src_x_in = sel_x_in[OUT_W-1:0];
      end

      if (sel_y_in > SAT_MAX) begin
         src_y_in = OUT_MAX;
      end else if (sel_y_in < SAT_MIN) begin
         src_y_in = OUT_MIN;
      end else begin
         src_y_in = sel_y_in[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[S_OUT]) begin
         src_x_ff      <= src_x_in;
         src_y_ff      <= src_y_in;
         out_region_ff <= region_ff[S_OUT-1];
      end
   end

   assign rsp_source_x      = src_x_ff;
   assign rsp_source_y      = src_y_ff;
   assign rsp_inside_region = out_region_ff;

`ifndef SYNTHESIS
   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[S_OFF])
      else $error("accepted request did not enter the pipeline");

   a_zero_radius_inside: assert property (@(posedge clock) disable iff (reset)
      valid_ff[S_DIST-1] && stage_ready[S_DIST] && inv_radius_ff == '0
      |=> region_ff[S_DIST])
      else $error("zero inverse radius did not mark the pixel inside");

   a_falloff_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[S_T] && region_ff[S_T] |-> t_ff != '0 && t_ff <= T_ONE)
      else $error("falloff term out of range inside the circle");
`endif

endmodule

>>> sim/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the bulge/pinch coordinate remap. Streams pixel
// requests through the valid/ready channels with random gaps and stalls,
// predicts every response with a fixed-point model of the radial remap, and
// compares source_x, source_y and inside_region in order. The CSR settings
// change only while the pipeline is empty.
// ============================================================================
module testbench
   import bpcr_pkg::*;
();

   localparam int FRAC_BITS       = 8;
   localparam int PIPE_LATENCY    = 29;
   localparam int STALL_LIMIT     = 2000;
   localparam int SCALE_SHIFT     = PROD_FRAC - FRAC_BITS;
   localparam int DIST_SHIFT      = CENTER_FRAC + INV_RADIUS_W - D_FRAC;
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_REQUESTS  = 150;

   typedef struct {
      logic [PIXEL_W-1:0]     px;
      logic [PIXEL_W-1:0]     py;
      logic signed [OUT_W-1:0] sx;
      logic signed [OUT_W-1:0] sy;
      logic                   in_region;
   } pixel_map_type;

   logic                    clock             = 1'b0;
   logic                    reset             = 1'b1;
   logic                    req_valid         = 1'b0;
   logic                    req_ready;
   logic [PIXEL_W-1:0]      req_pixel_x       = '0;
   logic [PIXEL_W-1:0]      req_pixel_y       = '0;
   logic                    rsp_valid;
   logic                    rsp_ready         = 1'b0;
   logic signed [OUT_W-1:0] rsp_source_x;
   logic signed [OUT_W-1:0] rsp_source_y;
   logic                    rsp_inside_region;
   logic                    csr_write_en      = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index         = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata         = '0;

   logic [CENTER_W-1:0]            cfg_center_x   = CENTER_X_RESET;
   logic [CENTER_W-1:0]            cfg_center_y   = CENTER_Y_RESET;
   logic [INV_RADIUS_W-1:0]        cfg_inv_radius = INV_RADIUS_RESET;
   logic signed [STRENGTH_W-1:0]   cfg_strength   = STRENGTH_RESET;

   pixel_map_type pending_remaps[$];
   int         mismatch_count = 0;
   int         idle_cycles    = 0;
   bit         req_steady     = 1'b0;
   bit         rsp_steady     = 1'b0;

   bulge_pinch_coordinate_remap #(
      .COORD_BITS (12),
      .FRAC_BITS  (FRAC_BITS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_source_x      (rsp_source_x),
      .rsp_source_y      (rsp_source_y),
      .rsp_inside_region (rsp_inside_region),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint isqrt_floor(input longint v);
      longint r;
      longint trial;
      r = 0;
      for (int b = 17; b >= 0; b--) begin
         trial = r | (longint'(1) << b);
         if (trial * trial <= v) r = trial;
      end
      return r;
   endfunction

   function automatic logic signed [OUT_W-1:0] clamp_out(input longint v);
      if (v > longint'(OUT_MAX)) return OUT_MAX;
      if (v < longint'(OUT_MIN)) return OUT_MIN;
      return v[OUT_W-1:0];
   endfunction

   function automatic logic signed [OUT_W-1:0] scale_axis(input longint off,
                                                          input longint factor,
                                                          input longint center);
      longint scaled;
      scaled = (off * factor + (longint'(1) << (SCALE_SHIFT - 1))) >>> SCALE_SHIFT;
      return clamp_out((center << (FRAC_BITS - CENTER_FRAC)) + scaled
                       - (longint'(1) << (FRAC_BITS - 1)));
   endfunction

   function automatic pixel_map_type remap_pixel(input logic [PIXEL_W-1:0] px,
                                                 input logic [PIXEL_W-1:0] py);
      pixel_map_type m;
      longint lx, ly, lcx, lcy, lir, lst;
      longint dx, dy, radial_dist, d16, t, t2, factor;
      lx  = px;
      ly  = py;
      lcx = cfg_center_x;
      lcy = cfg_center_y;
      lir = cfg_inv_radius;
      lst = cfg_strength;
      // offsets from the pixel center, Q.4
      dx  = (lx << CENTER_FRAC) + (longint'(1) << (CENTER_FRAC - 1)) - lcx;
      dy  = (ly << CENTER_FRAC) + (longint'(1) << (CENTER_FRAC - 1)) - lcy;
      radial_dist = isqrt_floor(dx * dx + dy * dy);
      d16  = (radial_dist * lir) >> DIST_SHIFT;
      m.px = px;
      m.py = py;
      m.in_region = (d16 < (longint'(1) << D_FRAC));
      if (m.in_region) begin
         t      = (longint'(1) << D_FRAC) - d16;
         t2     = (t * t) >> D_FRAC;
         factor = (longint'(1) << FACTOR_FRAC) - lst * t2;
         m.sx   = scale_axis(dx, factor, lcx);
         m.sy   = scale_axis(dy, factor, lcy);
      end else begin
         m.sx = clamp_out(lx << FRAC_BITS);
         m.sy = clamp_out(ly << FRAC_BITS);
      end
      return m;
   endfunction

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic logic [PIXEL_W-1:0] near_coord(input logic [CENTER_W-1:0] c,
                                                     input int reach);
      int v;
      v = c >> CENTER_FRAC;
      v = v - reach + int'($urandom_range(0, 2 * reach));
      if (v < 0) v = 0;
      if (v > (1 << PIXEL_W) - 1) v = (1 << PIXEL_W) - 1;
      return v[PIXEL_W-1:0];
   endfunction

   task automatic send_pixel(input logic [PIXEL_W-1:0] x, input logic [PIXEL_W-1:0] y);
      int gap;
      if ($urandom_range(0, 39) == 0) req_steady = ~req_steady;
      gap = req_steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_pixel_x <= x;
      req_pixel_y <= y;
      do @(posedge clock); while (!req_ready);
      pending_remaps.insert(pending_remaps.size(), remap_pixel(x, y));
   endtask

   task automatic drain_remaps();
      req_valid <= 1'b0;
      while (pending_remaps.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
   endtask

   task automatic set_remap_config(input logic [CENTER_W-1:0] cx,
                                   input logic [CENTER_W-1:0] cy,
                                   input logic [INV_RADIUS_W-1:0] ir,
                                   input logic [STRENGTH_W-1:0] st);
      drain_remaps();
      // upper data bits above a 16 bit register are don't-care: randomize them
      write_reg(CSR_CENTER_X, {4'($urandom), cx});
      write_reg(CSR_CENTER_Y, {4'($urandom), cy});
      write_reg(CSR_INV_RADIUS, ir);
      write_reg(CSR_STRENGTH, {4'($urandom), st});
      csr_write_en   <= 1'b0;
      cfg_center_x   = cx;
      cfg_center_y   = cy;
      cfg_inv_radius = ir;
      cfg_strength   = st;
   endtask

   task automatic test_reset_config();
      send_pixel(12'd2048, 12'd2048);
      send_pixel(12'd2047, 12'd2047);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd2147, 12'd2048);
      send_pixel(12'd2148, 12'd2048);
      send_pixel(12'd2048, 12'd1948);
   endtask

   task automatic test_whole_frame();
      set_remap_config(16'd0, 16'd0, 20'd0, 16'h8000);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd0);
      set_remap_config(16'hFFFF, 16'hFFFF, 20'd0, 16'h7FFF);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
   endtask

   task automatic test_radius_strength_extremes();
      set_remap_config(16'hFFFF, 16'd0, 20'hFFFFF, 16'h4000);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd4094, 12'd0);
      set_remap_config(16'd12345, 16'd54321, 20'd1, 16'hC000);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd771, 12'd3395);
      set_remap_config(16'd32000, 16'd33000, 20'd5000, 16'd0);
      send_pixel(12'd2010, 12'd2050);
   endtask

   task automatic test_random_phases();
      logic [CENTER_W-1:0]     cx, cy;
      logic [INV_RADIUS_W-1:0] ir;
      logic [STRENGTH_W-1:0]   st;
      int                      s, reach;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 2))
            0: begin cx = 16'($urandom); cy = 16'($urandom); end
            1: begin
               cx = 16'($urandom_range(28000, 37000));
               cy = 16'($urandom_range(28000, 37000));
            end
            default: begin
               cx = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
               cy = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
            end
         endcase
         case ($urandom_range(0, 3))
            0: ir = 20'd0;
            1: ir = 20'($urandom);
            2: ir = 20'($urandom_range(200, 30000));
            default: ir = 20'($urandom_range(30000, 1048575));
         endcase
         case ($urandom_range(0, 2))
            0: st = 16'($urandom);
            1: begin
               s  = int'($urandom_range(0, 32768)) - 16384;
               st = s[STRENGTH_W-1:0];
            end
            default: begin
               case ($urandom_range(0, 4))
                  0: st = 16'h8000;
                  1: st = 16'h7FFF;
                  2: st = 16'h4000;
                  3: st = 16'hC000;
                  default: st = 16'd0;
               endcase
            end
         endcase
         set_remap_config(cx, cy, ir, st);
         reach = (ir == 0) ? 2048 : ((1 << INV_RADIUS_W) / ir) + 2;
         if (reach > 2048) reach = 2048;
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if ($urandom_range(0, 9) < 6)
               send_pixel(near_coord(cx, reach), near_coord(cy, reach));
            else
               send_pixel(12'($urandom), 12'($urandom));
         end
      end
   endtask

   initial begin : result_checker
      int            stall;
      pixel_map_type want;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_steady = ~rsp_steady;
         stall = rsp_steady ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_remaps.size() == 0) begin
            $display("%0t: response with no request outstanding: x %0d y %0d inside %0d",
                     $time, rsp_source_x, rsp_source_y, rsp_inside_region);
            mismatch_count++;
         end else begin
            want = pending_remaps.pop_front();
            check_field("source_x", want.sx, rsp_source_x);
            check_field("source_y", want.sy, rsp_source_y);
            check_field("inside_region", want.in_region, rsp_inside_region);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_config();
      test_whole_frame();
      test_radius_strength_extremes();
      test_random_phases();
      drain_remaps();
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (mismatch_count == 0 && pending_remaps.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
